// ----- design/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants for the packed range table lookup block.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 10;
    localparam int SCALAR_W = 21;
    localparam int COUNT_W  = 11;
    localparam int PROP_W   = 3;
    localparam int LEN_W    = 9;
    localparam int LAST_W   = SCALAR_W + 1;

    // Operation codes carried in the op field of an input word.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // The one property code whose length field is a bit wider.
    localparam logic [PROP_W-1:0] PROP_WIDE_LEN = 3'd5;

    typedef struct packed {
        logic                op;
        logic [INDEX_W-1:0]  entry_index;
        logic [WORD_W-1:0]   entry_word;
        logic [SCALAR_W-1:0] scalar;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [PROP_W-1:0] property_res;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE
    } t_state;

    typedef struct packed {
        logic write_entry;
        logic load_search;
        logic issue_read;
        logic narrow;
        logic finish_hit;
        logic finish_miss;
    } t_ctrl_cmd;

    typedef struct packed {
        logic range_open;
        logic hit;
    } t_dp_status;

endpackage

// ----- design/prt_ctrl.sv -----
// ----------------------------------------------------------------------------
// prt_ctrl
// Sequencer for table loads and the binary search of a lookup.
// ----------------------------------------------------------------------------
module prt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  prt_pkg::t_dp_status i_status,
    output prt_pkg::t_ctrl_cmd  o_cmd,
    output logic              o_busy
);
    import prt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_op == OP_LOOKUP)) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                n_state = i_status.range_open ? ST_COMPARE : ST_IDLE;
            end
            ST_COMPARE: begin
                n_state = i_status.hit ? ST_IDLE : ST_PROBE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.write_entry = accept && (i_op == OP_LOAD);
                o_cmd.load_search = accept && (i_op == OP_LOOKUP);
            end
            ST_PROBE: begin
                o_cmd.issue_read  = i_status.range_open;
                o_cmd.finish_miss = !i_status.range_open;
            end
            ST_COMPARE: begin
                o_cmd.finish_hit = i_status.hit;
                o_cmd.narrow     = !i_status.hit;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/prt_datapath.sv -----
// ----------------------------------------------------------------------------
// prt_datapath
// Range table memory, search bounds, entry decode and result register.
// ----------------------------------------------------------------------------
module prt_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prt_pkg::t_ctrl_cmd          i_cmd,
    input  prt_pkg::t_in_item           i_item,
    input  logic                        i_cfg_we,
    input  logic [prt_pkg::COUNT_W-1:0] i_cfg_data,
    output prt_pkg::t_dp_status         o_status,
    output prt_pkg::t_out_item          o_result,
    output logic                        o_result_valid
);
    import prt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [WORD_W-1:0]   r_mem [TABLE_DEPTH];
    logic [WORD_W-1:0]   r_rd_data;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_lo;
    logic [CW-1:0]       r_end;
    logic [AW-1:0]       r_mid;
    logic [SCALAR_W-1:0] r_cp;
    t_out_item           r_result;
    logic                r_result_valid;

    logic [CW-1:0]       span;
    logic [AW-1:0]       mid;
    logic [PROP_W-1:0]   prop;
    logic [LEN_W-1:0]    len;
    logic [SCALAR_W-1:0] first;
    logic [LAST_W-1:0]   last;
    logic                cp_above;

    // Lower midpoint of the open range [lo, end).
    assign span = r_end - r_lo - CW'(1);
    assign mid  = AW'(r_lo + (span >> 1));

    assign prop  = r_rd_data[WORD_W-1 -: PROP_W];
    assign len   = (prop == PROP_WIDE_LEN) ? r_rd_data[29:21] : {1'b0, r_rd_data[28:21]};
    assign first = r_rd_data[SCALAR_W-1:0];
    assign last  = LAST_W'(first) + LAST_W'(len);
    assign cp_above = LAST_W'(r_cp) > last;

    assign o_status.range_open = (r_lo < r_end);
    assign o_status.hit        = (r_cp >= first) && !cp_above;

    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry && (32'(i_item.entry_index) < 32'(TABLE_DEPTH))) begin
            r_mem[AW'(i_item.entry_index)] <= i_item.entry_word;
        end
        if (i_cmd.issue_read) begin
            r_rd_data <= r_mem[mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_search) begin
            r_cp  <= i_item.scalar;
            r_lo  <= '0;
            r_end <= r_count;
        end else if (i_cmd.narrow) begin
            if (cp_above) begin
                r_lo <= CW'(r_mid) + CW'(1);
            end else begin
                r_end <= CW'(r_mid);
            end
        end
        if (i_cmd.issue_read) begin
            r_mid <= mid;
        end
        if (i_cmd.finish_hit) begin
            r_result.found        <= 1'b1;
            r_result.property_res <= prop;
        end else if (i_cmd.finish_miss) begin
            r_result <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.finish_hit || i_cmd.finish_miss;
            if (i_cfg_we) begin
                // A count above the table depth searches the whole table.
                if (32'(i_cfg_data) > 32'(TABLE_DEPTH)) begin
                    r_count <= CW'(TABLE_DEPTH);
                end else begin
                    r_count <= CW'(i_cfg_data);
                end
            end
        end
    end

endmodule

// ----- design/packed_range_table_lookup.sv -----
// ----------------------------------------------------------------------------
// packed_range_table_lookup
// Sorted table of packed range words with a binary-search classifier.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ------------------------------------
//  item in   start & !busy              i_item   (op, index, word, scalar)
//  result    o_result_valid (1 cycle)   o_result (found, property_res)
//  config    i_cfg_valid & o_cfg_ready  i_cfg_data (table_count)
//
// A load word is taken while the block is idle and writes the table at the
// accepting edge; busy stays low, so another word may follow at once. A
// lookup word raises busy; each probe passes through PROBE (address issue),
// then COMPARE (registered memory read and compare), and a miss is closed
// by a PROBE state that finds the range empty. The result strobe is
// registered from the final state and comes in the cycle after it. A
// lookup makes at most floor(log2(count))+1 probes (11 for a full table).
// Reset clears the state machine, the count and the result strobe; the
// table contents are not cleared. The receiver cannot stall the result, so
// the block never waits on the output side.
//
module packed_range_table_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  prt_pkg::t_in_item           i_item,
    output logic                        o_result_valid,
    output prt_pkg::t_out_item          o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [prt_pkg::COUNT_W-1:0] i_cfg_data
);
    import prt_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // The count register accepts a write in every cycle.
    assign o_cfg_ready = 1'b1;

    // The controller sequences the search; the datapath holds the table, bounds and result.
    prt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_item.op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    prt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_status       (status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // A result only ends a lookup that was in progress the cycle before.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a lookup in progress");

    // The controller is back in idle when the result is shown.
    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("block still busy while presenting a result");

    // A miss never carries a property.
    a_miss_zero_prop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.found) |-> (o_result.property_res == '0))
        else $error("miss result with nonzero property");

    // An accepted lookup occupies the block in the next cycle.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.op == OP_LOOKUP)) |=> busy)
        else $error("accepted lookup did not start a search");

    // A load never produces a result.
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.op == OP_LOAD)) |=> !o_result_valid)
        else $error("load word produced a result");

endmodule

// ----- verif/packed_range_table_lookup_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_range_table_lookup_tb
// Self-checking bench for the packed range table lookup block. It loads
// sorted and unsorted range tables, sets the search count across its whole
// range, and sends lookups that hit, just miss or land anywhere. A predictor
// in the bench mirrors the table and the count, and every result word is
// checked against the oldest expected lookup answer.
// ----------------------------------------------------------------------------
module packed_range_table_lookup_tb;

    import prt_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int SCALAR_MAX     = (1 << SCALAR_W) - 1;
    localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
    // This pause comfortably covers the tail of a full-table lookup still in
    // flight before the count is rewritten.
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 100;
    localparam int PRINT_CAP      = 50;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    logic                 o_result_valid;
    t_out_item            o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_data;

    // Predictor state, updated only at accepted handshakes.
    logic [WORD_W-1:0]    pred_table [DEPTH];
    logic [COUNT_W-1:0]   pred_count;
    t_out_item            pending_results [$];

    // Stimulus-side view of what has been loaded, used to aim lookups.
    logic [WORD_W-1:0]    stim_table [DEPTH];
    int                   stim_count;

    int                   error_count;
    int                   items_sent;
    int                   quiet_cycles;
    bit                   steady_flow;

    always #6 i_clk = ~i_clk;

    packed_range_table_lookup #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Range word decoding, shared by the predictor and the stimulus.
    // ------------------------------------------------------------------------
    function automatic int entry_first(input logic [WORD_W-1:0] w);
        return int'(w[SCALAR_W-1:0]);
    endfunction

    // The property that selects the wide length borrows its own low bit as
    // the ninth length bit.
    function automatic int entry_len(input logic [WORD_W-1:0] w);
        if (w[31:29] == PROP_WIDE_LEN) begin
            return int'(w[29:21]);
        end
        return int'(w[28:21]);
    endfunction

    function automatic logic [WORD_W-1:0] pack_entry(input logic [PROP_W-1:0] p,
                                                     input logic [7:0] len8,
                                                     input int first);
        return {p, len8, first[SCALAR_W-1:0]};
    endfunction

    // Binary search over the first count entries, as the block performs it.
    // A count beyond the table depth is clipped to the depth.
    function automatic t_out_item classify_scalar(input logic [SCALAR_W-1:0] cp_bits);
        t_out_item r;
        int        n;
        int        lo;
        int        hi;
        int        mid;
        int        cp;
        int        first;
        int        last;
        r     = '0;
        cp    = int'(cp_bits);
        n     = (int'(pred_count) > DEPTH) ? DEPTH : int'(pred_count);
        lo    = 0;
        hi    = n - 1;
        while (hi >= lo) begin
            mid   = lo + (hi - lo) / 2;
            first = entry_first(pred_table[mid]);
            last  = first + entry_len(pred_table[mid]);
            if (cp >= first && cp <= last) begin
                r.found        = 1'b1;
                r.property_res = pred_table[mid][31:29];
                hi             = lo - 1;
            end else if (cp > last) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: checks each result word first, then applies the config and
    // input words accepted at the same edge, so a lookup accepted now never
    // matches a result that leaves now.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0d prop=%0d",
                                              o_result.found, o_result.property_res));
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.found !== want.found) begin
                        report_mismatch($sformatf("found is %0b, expected %0b",
                                                  o_result.found, want.found));
                    end
                    if (o_result.property_res !== want.property_res) begin
                        report_mismatch($sformatf("property_res is %0d, expected %0d",
                                                  o_result.property_res,
                                                  want.property_res));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                pred_count = i_cfg_data;
            end
            if (start && !busy) begin
                if (i_item.op == OP_LOAD) begin
                    if (int'(i_item.entry_index) < DEPTH) begin
                        pred_table[i_item.entry_index] = i_item.entry_word;
                    end
                end else begin
                    pending_results.push_back(classify_scalar(i_item.scalar));
                end
            end
        end
    end

    // The watchdog only counts cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving. Every task returns at a rising edge. send_item leaves start
    // high after the accepting edge so the next word can follow at once;
    // end_burst lowers it when the stream pauses.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_in_item it);
        if (!steady_flow && $urandom_range(0, 99) < 7) begin
            // Idle with junk on the item bus; it must not be taken.
            start  <= 1'b0;
            i_item <= {$urandom, $urandom};
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic end_burst();
        start <= 1'b0;
    endtask

    task automatic load_entry(input int idx, input logic [WORD_W-1:0] w);
        t_in_item it;
        it.op          = OP_LOAD;
        it.entry_index = idx[INDEX_W-1:0];
        it.entry_word  = w;
        it.scalar      = SCALAR_W'($urandom);
        stim_table[idx] = w;
        send_item(it);
    endtask

    task automatic lookup_scalar(input int cp);
        t_in_item it;
        it.op          = OP_LOOKUP;
        it.entry_index = INDEX_W'($urandom);
        it.entry_word  = $urandom;
        it.scalar      = cp[SCALAR_W-1:0];
        send_item(it);
    endtask

    // The count is only rewritten with the block idle: every expected result
    // in, then a settling pause for any lookup still in flight.
    task automatic set_count(input int c);
        end_burst();
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (!steady_flow && $urandom_range(0, 99) < 7) begin
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c[COUNT_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        stim_count = c;
    endtask

    // ------------------------------------------------------------------------
    // Table builders and lookup targets.
    // ------------------------------------------------------------------------

    // Non-overlapping ranges in rising order, spread over the code space.
    task automatic load_sorted(input int n);
        int                cursor;
        int                span;
        logic [WORD_W-1:0] w;
        span   = 2097152 / n - 520;
        if (span < 0) begin
            span = 0;
        end
        cursor = $urandom_range(0, 64);
        for (int i = 0; i < n; i++) begin
            if (cursor > SCALAR_MAX) begin
                cursor = SCALAR_MAX;
            end
            w = pack_entry(PROP_W'($urandom_range(0, 7)), 8'($urandom), cursor);
            load_entry(i, w);
            cursor = cursor + entry_len(w) + 1 + $urandom_range(0, span);
        end
    endtask

    task automatic load_unsorted(input int n);
        for (int i = 0; i < n; i++) begin
            load_entry(i, $urandom);
        end
    endtask

    function automatic int pick_hit(input int n);
        logic [WORD_W-1:0] w;
        int                cp;
        w  = stim_table[$urandom_range(0, n - 1)];
        cp = entry_first(w) + $urandom_range(0, entry_len(w));
        return (cp > SCALAR_MAX) ? SCALAR_MAX : cp;
    endfunction

    // One past either end of a loaded range.
    function automatic int pick_near_miss(input int n);
        logic [WORD_W-1:0] w;
        int                cp;
        w = stim_table[$urandom_range(0, n - 1)];
        if ($urandom_range(0, 1)) begin
            cp = entry_first(w) + entry_len(w) + 1;
        end else begin
            cp = entry_first(w) - 1;
        end
        if (cp < 0) begin
            cp = 0;
        end
        return (cp > SCALAR_MAX) ? SCALAR_MAX : cp;
    endfunction

    // Mixed lookups against the current count; with noise, a few loads of
    // random words land between them and disturb the ordering.
    task automatic random_lookups(input int k, input bit with_noise);
        int n;
        int r;
        n = (stim_count > DEPTH) ? DEPTH : stim_count;
        for (int i = 0; i < k; i++) begin
            r = $urandom_range(0, 99);
            if (with_noise && r < 5) begin
                load_entry($urandom_range(0, DEPTH - 1), $urandom);
            end else if (n == 0 || r >= 75) begin
                lookup_scalar($urandom_range(0, SCALAR_MAX));
            end else if (r < 50) begin
                lookup_scalar(pick_hit(n));
            end else begin
                lookup_scalar(pick_near_miss(n));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // With a count of zero nothing is probed, whatever the table holds.
    task automatic test_empty_table();
        lookup_scalar(0);
        lookup_scalar(SCALAR_MAX);
        load_entry(0, '0);
        load_entry(DEPTH - 1, '1);
        set_count(0);
        lookup_scalar($urandom_range(0, SCALAR_MAX));
        lookup_scalar(SCALAR_MAX);
    endtask

    // Hand-built ranges: a zero property that still hits, range edges, the
    // wide length that only reaches its far end with nine length bits, and a
    // range at the top of the code space whose end runs past it.
    task automatic test_directed_ranges();
        load_entry(0, pack_entry(3'd0, 8'd0, 0));
        load_entry(1, pack_entry(3'd7, 8'd255, 16));
        load_entry(2, pack_entry(PROP_WIDE_LEN, 8'd255, 'h400));
        load_entry(3, pack_entry(3'd4, 8'd255, 'h1000));
        load_entry(4, pack_entry(3'd1, 8'd3, 'h1200));
        load_entry(5, pack_entry(3'd3, 8'd255, SCALAR_MAX));
        set_count(6);
        lookup_scalar(0);
        lookup_scalar(1);
        lookup_scalar(16);
        lookup_scalar(271);
        lookup_scalar(272);
        lookup_scalar('h5FF);
        lookup_scalar('h600);
        lookup_scalar('h10FF);
        lookup_scalar('h1100);
        lookup_scalar('h1203);
        lookup_scalar(SCALAR_MAX);
        lookup_scalar(SCALAR_MAX - 1);
        // A single-entry search probes only entry zero.
        set_count(1);
        lookup_scalar(0);
        lookup_scalar(16);
    endtask

    // Every entry loaded back to back, then searched at the full depth and
    // with the largest count, which the block clips to the depth.
    task automatic test_full_table();
        steady_flow = 1'b1;
        load_sorted(DEPTH);
        set_count(DEPTH);
        random_lookups(60, 1'b0);
        set_count(COUNT_MAX);
        random_lookups(40, 1'b0);
        steady_flow = 1'b0;
    endtask

    // Phases with a random count, mostly small, a prefix reloaded for each small
    // count and some large ones, usually sorted, and lookups with loads mixed
    // in. All entries are written by now, so any count is safe to search.
    task automatic test_random_phases();
        int first_item;
        int c;
        int n;
        int r;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                c = 0;
            end else if (r < 20) begin
                c = 1;
            end else if (r < 70) begin
                c = $urandom_range(2, 32);
            end else if (r < 85) begin
                c = $urandom_range(33, DEPTH);
            end else begin
                c = $urandom_range(DEPTH + 1, COUNT_MAX);
            end
            n = (c > DEPTH) ? DEPTH : c;
            if (n > 0 && (n <= 64 || $urandom_range(0, 99) < 30)) begin
                if ($urandom_range(0, 99) < 80) begin
                    load_sorted(n);
                end else begin
                    load_unsorted(n);
                end
            end
            set_count(c);
            random_lookups($urandom_range(20, 60), 1'b1);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        pred_count  = '0;
        stim_count  = 0;
        error_count = 0;
        items_sent  = 0;
        quiet_cycles = 0;
        steady_flow = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            pred_table[i] = '0;
            stim_table[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_ranges();
        test_full_table();
        test_random_phases();

        end_burst();
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d lookup results never arrived",
                                      pending_results.size()));
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/prt_pkg.sv
design/prt_ctrl.sv
design/prt_datapath.sv
design/packed_range_table_lookup.sv
verif/packed_range_table_lookup_tb.sv
